@@ hw/rtl/size_class_block_pool_assert.svh @@
// Assertion macros shared by the size class block pool RTL.
`ifndef SIZE_CLASS_BLOCK_POOL_ASSERT_SVH
`define SIZE_CLASS_BLOCK_POOL_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define SCBP_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define SCBP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/scbp_pkg.sv @@
// Types, constants and codes shared by the size class block pool.
`default_nettype none

package scbp_pkg;

   localparam int POOL_BLOCKS    = 32;
   localparam int SIZE_CLASSES   = 4;
   localparam int NUM_CLASS_REGS = 4;
   localparam int NUM_REGS       = 2 * NUM_CLASS_REGS;
   localparam int BYTES_W        = 21;
   localparam int COUNT_W        = 6;
   localparam int STATUS_W       = 2;
   localparam int CLASS_W        = $clog2(NUM_CLASS_REGS);
   localparam int HANDLE_W       = $clog2(POOL_BLOCKS);
   localparam int BASE_W         = $clog2(POOL_BLOCKS + 1);
   localparam int SUM_W          = ((BASE_W > COUNT_W) ? BASE_W : COUNT_W) + 1;
   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = BYTES_W;

   localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(SIZE_CLASSES - 1);

   // Low bit of a register index picks bytes or count within a class.
   localparam logic REG_KIND_BYTES = 1'b0;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_NO_BLOCK   = 2'd1,
      STATUS_BAD_HANDLE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DONE
   } seq_state_type;

   // Sequencer to class unit: which class, and where its blocks start.
   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [BASE_W-1:0]  base;
   } scan_step_type;

   // Class unit to sequencer.
   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] index;
      logic [BASE_W-1:0]   end_pos;
   } class_result_type;

endpackage

`default_nettype wire

@@ hw/rtl/size_class_block_pool.sv @@
// Top level of the size class block pool allocator.
//
//   channel  ports                                          role
//   req      req_valid/ready, op, request_bytes, free_handle  allocate or free request in
//   rsp      rsp_valid/ready, status, granted_handle          one response per request
//   csr      csr_valid/ready, index, wdata                    class size and count writes
//
// A request is captured, then passes each size class in turn through the
// shared class unit, then commits the busy map and loads the response
// register.
// The class unit handles one class per cycle: range of its blocks, size match
// and lowest free block in that range; the scan also sums the carved total.
// Synchronous reset clears the busy map (all free), state, rsp_valid and class regs.
// A held response does not block capture; only the commit step waits for it.
// csr_ready is always high.
`default_nettype none

module size_class_block_pool
   import scbp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_op,
   input  wire logic [BYTES_W-1:0]     req_request_bytes,
   input  wire logic [HANDLE_W-1:0]    req_free_handle,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [HANDLE_W-1:0]         rsp_granted_handle,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "size_class_block_pool_assert.svh"

   logic [BYTES_W-1:0]     class_bytes [NUM_CLASS_REGS];
   logic [COUNT_W-1:0]     class_count [NUM_CLASS_REGS];
   scan_step_type          step;
   class_result_type       result;
   logic [BYTES_W-1:0]     want_bytes;
   logic [POOL_BLOCKS-1:0] busy_map;
   logic [BYTES_W-1:0]     sel_bytes;
   logic [COUNT_W-1:0]     sel_count;

   scbp_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .class_bytes (class_bytes),
      .class_count (class_count)
   );

   // class under scan feeds the shared unit
   assign sel_bytes = class_bytes[step.cls];
   assign sel_count = class_count[step.cls];

   scbp_class_unit u_unit (
      .class_bytes (sel_bytes),
      .class_count (sel_count),
      .want_bytes  (want_bytes),
      .busy_map    (busy_map),
      .step        (step),
      .result      (result)
   );

   scbp_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_request_bytes  (req_request_bytes),
      .req_free_handle    (req_free_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_handle (rsp_granted_handle),
      .step               (step),
      .want_bytes         (want_bytes),
      .busy_map           (busy_map),
      .result             (result)
   );

   // the sequencer must drop ready once a request is taken
   `SCBP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while scan busy")

   // failed requests never hand out a block number
   `SCBP_ASSERT_SAME(a_zero_handle_on_fail, clock, reset, rsp_valid && (rsp_status != STATUS_DONE), rsp_granted_handle == '0, "nonzero handle on failed request")

endmodule

`default_nettype wire

@@ hw/rtl/scbp_csr_regs.sv @@
// Class configuration registers of the size class block pool.
`default_nettype none

module scbp_csr_regs
   import scbp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [BYTES_W-1:0]          class_bytes [NUM_CLASS_REGS],
   output logic [COUNT_W-1:0]          class_count [NUM_CLASS_REGS]
);

   logic [BYTES_W-1:0] bytes_ff [NUM_CLASS_REGS];
   logic [COUNT_W-1:0] count_ff [NUM_CLASS_REGS];
   logic [CLASS_W-1:0] cls_sel;
   logic               in_list;

   assign csr_ready = 1'b1;
   assign in_list   = csr_index < CSR_INDEX_W'(NUM_REGS);
   assign cls_sel   = csr_index[CLASS_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASS_REGS; c++) begin
            bytes_ff[c] <= '0;
            count_ff[c] <= '0;
         end
      end else if (csr_valid && in_list) begin
         if (csr_index[0] == REG_KIND_BYTES) begin
            bytes_ff[cls_sel] <= csr_wdata[BYTES_W-1:0];
         end else begin
            count_ff[cls_sel] <= csr_wdata[COUNT_W-1:0];
         end
      end
   end

   assign class_bytes = bytes_ff;
   assign class_count = count_ff;

endmodule

`default_nettype wire

@@ hw/rtl/scbp_class_unit.sv @@
// Shared class unit: range of one class, size match and lowest free block.
`default_nettype none

module scbp_class_unit
   import scbp_pkg::*;
(
   input  wire logic [BYTES_W-1:0]     class_bytes,
   input  wire logic [COUNT_W-1:0]     class_count,
   input  wire logic [BYTES_W-1:0]     want_bytes,
   input  wire logic [POOL_BLOCKS-1:0] busy_map,
   input  wire scan_step_type          step,
   output class_result_type            result
);

   logic [SUM_W-1:0]       sum;
   logic [BASE_W-1:0]      end_pos;
   logic [POOL_BLOCKS-1:0] cand;
   logic [POOL_BLOCKS-1:0] lowest;
   logic [HANDLE_W-1:0]    index;

   always_comb begin
      sum     = SUM_W'(step.base) + SUM_W'(class_count);
      // clip the running block number at the pool size
      end_pos = (sum > SUM_W'(POOL_BLOCKS)) ? BASE_W'(POOL_BLOCKS) : BASE_W'(sum);

      for (int b = 0; b < POOL_BLOCKS; b++) begin
         cand[b] = !busy_map[b] && (BASE_W'(b) >= step.base) && (BASE_W'(b) < end_pos);
      end

      // isolate lowest candidate, then one-hot to binary
      lowest = cand & (~cand + POOL_BLOCKS'(1));
      index  = '0;
      for (int b = 0; b < POOL_BLOCKS; b++) begin
         if (lowest[b]) begin
            index = index | HANDLE_W'(b);
         end
      end

      result.hit     = (class_bytes == want_bytes) && (|cand);
      result.index   = index;
      result.end_pos = end_pos;
   end

endmodule

`default_nettype wire

@@ hw/rtl/scbp_seq.sv @@
// Sequencer: request capture, class scan, busy map and response register.
`default_nettype none

module scbp_seq
   import scbp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_op,
   input  wire logic [BYTES_W-1:0]     req_request_bytes,
   input  wire logic [HANDLE_W-1:0]    req_free_handle,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [HANDLE_W-1:0]         rsp_granted_handle,
   output scan_step_type               step,
   output logic [BYTES_W-1:0]          want_bytes,
   output logic [POOL_BLOCKS-1:0]      busy_map,
   input  wire class_result_type       result
);

   seq_state_type          state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;
   logic [HANDLE_W-1:0]    handle_ff, handle_in;
   logic [CLASS_W-1:0]     cls_ff, cls_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic                   found_ff, found_in;
   logic [HANDLE_W-1:0]    grant_ff, grant_in;
   logic [POOL_BLOCKS-1:0] busy_ff, busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]    rsp_handle_ff, rsp_handle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bytes_ff      <= bytes_in;
      handle_ff     <= handle_in;
      cls_ff        <= cls_in;
      base_ff       <= base_in;
      found_ff      <= found_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bytes_in      = bytes_ff;
      handle_in     = handle_ff;
      cls_in        = cls_ff;
      base_in       = base_ff;
      found_in      = found_ff;
      grant_in      = grant_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      req_ready     = (state_ff == SEQ_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_op);
               bytes_in  = req_request_bytes;
               handle_in = req_free_handle;
               cls_in    = '0;
               base_in   = '0;
               found_in  = 1'b0;
               grant_in  = '0;
               state_in  = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            base_in = result.end_pos;
            if (op_ff == OP_ALLOC && !found_ff && result.hit) begin
               found_in = 1'b1;
               grant_in = result.index;
            end
            if (cls_ff == LAST_CLASS) begin
               state_in = SEQ_DONE;
            end else begin
               cls_in = cls_ff + CLASS_W'(1);
            end
         end
         SEQ_DONE: begin
            // base_ff now holds the carved total
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
               if (op_ff == OP_ALLOC) begin
                  rsp_handle_in = grant_ff;
                  if (found_ff) begin
                     rsp_status_in     = STATUS_DONE;
                     busy_in[grant_ff] = 1'b1;
                  end else begin
                     rsp_status_in = STATUS_NO_BLOCK;
                  end
               end else begin
                  rsp_handle_in = '0;
                  if (BASE_W'(handle_ff) < base_ff) begin
                     rsp_status_in      = STATUS_DONE;
                     busy_in[handle_ff] = 1'b0;
                  end else begin
                     rsp_status_in = STATUS_BAD_HANDLE;
                  end
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign step.cls           = cls_ff;
   assign step.base          = base_ff;
   assign want_bytes         = bytes_ff;
   assign busy_map           = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_handle = rsp_handle_ff;

endmodule

`default_nettype wire

@@ tb/size_class_block_pool_test.sv @@
// Self-checking testbench for the size class block pool allocator.
module size_class_block_pool_test
   import scbp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [BYTES_W-1:0] BYTES_ALL_ONES = '1;
   localparam logic [BYTES_W-1:0] BYTES_TOP      = 21'd1048576;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 50;
   localparam int STUCK_LIMIT    = 1000;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   // One line of the directed stimulus: a request or a register write.
   typedef struct packed {
      row_kind_type             kind;
      op_type                   op;
      logic [BYTES_W-1:0]       bytes;
      logic [HANDLE_W-1:0]      handle;
      logic [CSR_INDEX_W-1:0]   csr_index;
      logic [CSR_DATA_W-1:0]    csr_data;
      logic                     typed;
      status_type               want_status;
      logic [HANDLE_W-1:0]      want_handle;
   } stim_row_type;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
   } pool_result_type;

   // Clock, reset and block ports; every input is known from time zero.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_op = 1'b0;
   logic [BYTES_W-1:0]     req_request_bytes = '0;
   logic [HANDLE_W-1:0]    req_free_handle = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [HANDLE_W-1:0]    rsp_granted_handle;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow of the pool: class registers and busy marks, updated on every
   // accepted request and register write.
   logic [BYTES_W-1:0]     cls_bytes [NUM_CLASS_REGS] = '{default: '0};
   logic [COUNT_W-1:0]     cls_count [NUM_CLASS_REGS] = '{default: '0};
   logic [POOL_BLOCKS-1:0] busy_blocks = '0;

   pool_result_type expected_results [$];
   int           mismatch_count = 0;
   int           stuck_cycles = 0;
   bit           idle_on = 1'b1;   // cleared for back-to-back stretches

   size_class_block_pool uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_request_bytes  (req_request_bytes),
      .req_free_handle    (req_free_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_handle (rsp_granted_handle),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Blocks carved by the current class counts, clipped to the pool size.
   function automatic int carved_blocks();
      int total;
      total = 0;
      for (int c = 0; c < SIZE_CLASSES; c++) total += cls_count[c];
      if (total > POOL_BLOCKS) total = POOL_BLOCKS;
      return total;
   endfunction

   // Allocate: lowest free block whose class size matches exactly.
   // Free: clear the mark if the handle is carved, flag it otherwise.
   function automatic void predict_pool_step(input op_type op,
                                             input logic [BYTES_W-1:0] bytes,
                                             input logic [HANDLE_W-1:0] handle,
                                             output status_type st,
                                             output logic [HANDLE_W-1:0] gh);
      int  total;
      int  base;
      int  stop;
      bit  found;
      total = carved_blocks();
      st    = STATUS_DONE;
      gh    = '0;
      found = 1'b0;
      if (op == OP_ALLOC) begin
         st   = STATUS_NO_BLOCK;
         base = 0;
         for (int c = 0; c < SIZE_CLASSES; c++) begin
            stop = base + cls_count[c];
            if (stop > total) stop = total;
            if (!found && cls_bytes[c] == bytes) begin
               for (int b = base; b < stop; b++) begin
                  if (!found && !busy_blocks[b]) begin
                     busy_blocks[b] = 1'b1;
                     gh    = HANDLE_W'(b);
                     st    = STATUS_DONE;
                     found = 1'b1;
                  end
               end
            end
            base = stop;
         end
      end else if (handle < total) begin
         busy_blocks[handle] = 1'b0;
      end else begin
         st = STATUS_BAD_HANDLE;
      end
   endfunction

   function automatic stim_row_type req_row(op_type op, logic [BYTES_W-1:0] bytes,
                                            logic [HANDLE_W-1:0] handle, logic typed,
                                            status_type st, logic [HANDLE_W-1:0] gh);
      stim_row_type r;
      r             = '0;
      r.kind        = ROW_REQUEST;
      r.op          = op;
      r.bytes       = bytes;
      r.handle      = handle;
      r.typed       = typed;
      r.want_status = st;
      r.want_handle = gh;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_W-1:0] index,
                                            logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_CSR;
      r.csr_index = index;
      r.csr_data  = data;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Present one request after a random gap, hold it until taken, then
   // record its expected response. Typed rows override the prediction,
   // the predictor still runs so the busy map stays in step.
   task automatic send_request(stim_row_type row);
      int            gap;
      status_type    st;
      logic [HANDLE_W-1:0] gh;
      pool_result_type res;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= row.op;
      req_request_bytes <= row.bytes;
      req_free_handle   <= row.handle;
      do @(posedge clock); while (!req_ready);
      predict_pool_step(row.op, row.bytes, row.handle, st, gh);
      if (row.typed) begin
         st = row.want_status;
         gh = row.want_handle;
      end
      res.status = st;
      res.handle = gh;
      expected_results.push_back(res);
   endtask

   // Register write; the shadow takes it on the handshake. Indexes past the
   // register file are dropped by the block.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index < NUM_REGS) begin
         if (index[0] == REG_KIND_BYTES) cls_bytes[index[CLASS_W:1]] = data;
         else cls_count[index[CLASS_W:1]] = data[COUNT_W-1:0];
      end
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop requesting and wait for every outstanding response, plus a margin
   // for the commit step, so registers can be rewritten safely.
   task automatic drain_pool();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Response side: random back-pressure per response, none when idling is off.
   initial begin : rsp_side
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Response checker: in order against the oldest expectation.
   always @(posedge clock) begin : check_responses
      pool_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_granted_handle !== want.handle)
               report_mismatch("granted_handle", rsp_granted_handle, want.handle);
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[size_class_block_pool] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : main
      stim_row_type         directed_rows [$];
      stim_row_type         row;
      bit                   req_open;
      bit                   csr_open;
      int                   alloc_pct;
      int                   pick;
      int                   total;
      op_type               op;
      logic [BYTES_W-1:0]   bytes;
      logic [HANDLE_W-1:0]  handle;
      logic [CSR_DATA_W-1:0] data;
      logic [COUNT_W-1:0]   cnt;

      req_open = 1'b0;
      csr_open = 1'b0;

      // Straight after reset nothing is carved: every allocate misses and
      // every handle is unknown.
      directed_rows.push_back(req_row(OP_ALLOC, '0, '0, 1'b1, STATUS_NO_BLOCK, '0));
      directed_rows.push_back(req_row(OP_FREE, BYTES_ALL_ONES, '0, 1'b1, STATUS_BAD_HANDLE, '0));
      directed_rows.push_back(req_row(OP_FREE, '0, '1, 1'b1, STATUS_BAD_HANDLE, '0));
      // Zero-byte class of 2, top-size class of 3, a class of 40 that runs
      // past the pool (count written with junk above its field), and a
      // fourth class left with no blocks. Two writes past the register file.
      directed_rows.push_back(csr_row(4'd0, '0));
      directed_rows.push_back(csr_row(4'd1, 21'd2));
      directed_rows.push_back(csr_row(4'd2, BYTES_TOP));
      directed_rows.push_back(csr_row(4'd3, 21'd3));
      directed_rows.push_back(csr_row(4'd4, 21'd64));
      directed_rows.push_back(csr_row(4'd5, 21'h1FFFE8));
      directed_rows.push_back(csr_row(4'd6, 21'd64));
      directed_rows.push_back(csr_row(4'd7, 21'd5));
      directed_rows.push_back(csr_row(4'd8, BYTES_ALL_ONES));
      directed_rows.push_back(csr_row(4'd15, '0));
      directed_rows.push_back(req_row(OP_ALLOC, '0, '1, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, '0, '0, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, '0, '0, 1'b1, STATUS_NO_BLOCK, '0));
      directed_rows.push_back(req_row(OP_ALLOC, BYTES_TOP, '0, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, 21'd64, '0, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, BYTES_ALL_ONES, '0, 1'b1, STATUS_NO_BLOCK, '0));
      directed_rows.push_back(req_row(OP_ALLOC, 21'd7, '0, 1'b1, STATUS_NO_BLOCK, '0));
      // Freeing a block that is already free still reports done.
      directed_rows.push_back(req_row(OP_FREE, '0, '1, 1'b1, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_FREE, '0, '0, 1'b1, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, '0, '0, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_FREE, '0, 5'd5, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, 21'd64, '0, 1'b0, STATUS_DONE, '0));
      // Shrink to a single block: busy marks beyond it stay put.
      directed_rows.push_back(csr_row(4'd1, 21'd1));
      directed_rows.push_back(csr_row(4'd3, '0));
      directed_rows.push_back(csr_row(4'd5, '0));
      directed_rows.push_back(csr_row(4'd7, '0));
      directed_rows.push_back(req_row(OP_FREE, '0, 5'd2, 1'b1, STATUS_BAD_HANDLE, '0));
      directed_rows.push_back(req_row(OP_FREE, '0, '1, 1'b1, STATUS_BAD_HANDLE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, '0, '0, 1'b1, STATUS_NO_BLOCK, '0));
      directed_rows.push_back(req_row(OP_ALLOC, BYTES_TOP, '0, 1'b1, STATUS_NO_BLOCK, '0));
      directed_rows.push_back(req_row(OP_FREE, '0, '0, 1'b1, STATUS_DONE, '0));
      // Grow again: the old busy marks count once more.
      directed_rows.push_back(csr_row(4'd3, 21'd3));
      directed_rows.push_back(csr_row(4'd5, 21'd63));
      directed_rows.push_back(csr_row(4'd7, 21'd32));
      directed_rows.push_back(req_row(OP_ALLOC, BYTES_TOP, '0, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, 21'd64, '0, 1'b0, STATUS_DONE, '0));
      directed_rows.push_back(req_row(OP_ALLOC, 21'd64, '0, 1'b0, STATUS_DONE, '0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk; register rows only once the pool has gone quiet.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (req_open) drain_pool();
            req_open = 1'b0;
            csr_write(row.csr_index, row.csr_data);
            csr_open = 1'b1;
         end else begin
            if (csr_open) csr_release();
            csr_open = 1'b0;
            send_request(row);
            req_open = 1'b1;
         end
      end

      // Random phases: fresh class setup, then a burst of requests whose
      // sizes mostly hit a configured class and whose frees mostly land on
      // carved blocks, so the busy map fills and empties.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pool();
         idle_on = (phase % 3 != 2);
         for (int c = 0; c < NUM_CLASS_REGS; c++) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0: bytes = '0;
               1: bytes = BYTES_TOP;
               2: bytes = BYTES_ALL_ONES;
               3: bytes = cls_bytes[(c + NUM_CLASS_REGS - 1) % NUM_CLASS_REGS];
               7: bytes = BYTES_W'($urandom);
               default: bytes = 21'd16 << $urandom_range(0, 8);
            endcase
            pick = $urandom_range(0, 5);
            if (phase == 1) cnt = 6'd32;
            else if (phase == 4) cnt = '0;
            else if (pick == 0) cnt = '0;
            else if (pick == 1) cnt = 6'd32;
            else if (pick == 2) cnt = '1;
            else cnt = COUNT_W'($urandom_range(1, 12));
            data = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
            data[COUNT_W-1:0] = cnt;
            csr_write(CSR_INDEX_W'(2 * c), bytes);
            csr_write(CSR_INDEX_W'(2 * c + 1), data);
         end
         if ($urandom_range(0, 3) == 0)
            csr_write(CSR_INDEX_W'($urandom_range(NUM_REGS, 15)), CSR_DATA_W'($urandom));
         csr_release();

         alloc_pct = $urandom_range(30, 70);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            op     = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            bytes  = BYTES_W'($urandom);
            handle = HANDLE_W'($urandom_range(0, POOL_BLOCKS - 1));
            total  = carved_blocks();
            if (op == OP_ALLOC && $urandom_range(0, 99) < 85)
               bytes = cls_bytes[$urandom_range(0, NUM_CLASS_REGS - 1)];
            if (op == OP_FREE && total > 0 && $urandom_range(0, 99) < 80)
               handle = HANDLE_W'($urandom_range(0, total - 1));
            send_request(req_row(op, bytes, handle, 1'b0, STATUS_DONE, '0));
         end
      end

      drain_pool();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[size_class_block_pool] OK");
      end else begin
         $display("[size_class_block_pool] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/scbp_pkg.sv
hw/rtl/scbp_csr_regs.sv
hw/rtl/scbp_class_unit.sv
hw/rtl/scbp_seq.sv
hw/rtl/size_class_block_pool.sv
tb/size_class_block_pool_test.sv
